@@ hw/rtl/cursor_overlay_save_under_top_defines.svh @@
// ----------------------------------------------------------------------------
// cursor overlay assertion macros
// shared concurrent assertion wrappers, clocked on clk; COSU_ASSERT is quiet during reset
// ----------------------------------------------------------------------------
`ifndef CURSOR_OVERLAY_SAVE_UNDER_TOP_DEFINES_SVH
`define CURSOR_OVERLAY_SAVE_UNDER_TOP_DEFINES_SVH

// implication checked on every rising edge outside reset
`define COSU_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// same check, also armed while reset is asserted
`define COSU_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/cosu_pkg.sv @@
// ----------------------------------------------------------------------------
// cosu_pkg
// types and fixed constants of the cursor overlay with save-under
// ----------------------------------------------------------------------------
package cosu_pkg;

	localparam int COORD_W  = 12;
	localparam int SCREEN_W = 13;
	localparam int CELL_W   = 4;
	localparam int COLOR_W  = 24;
	localparam int PIXEL_W  = 32;
	localparam int MASK_W   = 64;
	localparam int MASK_REGS = 4;
	localparam int MASK_BITS = 256;
	localparam int APB_AW   = 6;
	localparam int APB_DW   = 64;
	localparam int IN_DW    = 64;
	localparam int OUT_DW   = 64;

	localparam logic [COLOR_W-1:0]  COLOR_RST  = 24'hFFFFFF;
	localparam logic [COORD_W-1:0]  WIDTH_RST  = 12'd1280;
	localparam logic [COORD_W-1:0]  HEIGHT_RST = 12'd720;

	typedef enum logic {
		CMD_DRAW  = 1'b0,
		CMD_CLEAR = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		REG_COLOR   = 3'd0,
		REG_WIDTH   = 3'd1,
		REG_HEIGHT  = 3'd2,
		REG_MASK_0  = 3'd3,
		REG_MASK_1  = 3'd4,
		REG_MASK_2  = 3'd5,
		REG_MASK_3  = 3'd6
	} cfg_reg_t;

endpackage

@@ hw/rtl/cursor_overlay_save_under_top.sv @@
// an input transaction reaches the master side through the stage 1, stage 2 and stage 3 registers
// throughput: one cell per cycle while m_tready does not stall, set by the single-port
//   save-under memory that is read (clear) or written (draw) as a cell leaves stage 1
// reset: arst_n clears pipeline valids, drawn flag and per-cell valid bits at once;
//   registers return to color ffffff, 1280x720, empty mask; no clearing pass
// ----------------------------------------------------------------------------
// cursor_overlay_save_under_top
// hardware mouse cursor with save-under, one cursor cell per transaction
// ----------------------------------------------------------------------------
`include "cursor_overlay_save_under_top_defines.svh"

module cursor_overlay_save_under_top #(
	parameter int CURSOR_SIZE = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// slave side
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// cursor_x[11:0], cursor_y[23:12], cell_col[27:24], cell_row[31:28], fb_pixel[63:32]
	input  logic [cosu_pkg::IN_DW-1:0] s_tdata,
	// cmd[0]
	input  logic                       s_tuser,
	// master side
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// write_x[12:0], write_y[25:13], write_color[57:26], zero[63:58]
	output logic [cosu_pkg::OUT_DW-1:0] m_tdata,
	// write_enable[0]
	output logic                       m_tuser,
	// configuration
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [cosu_pkg::APB_AW-1:0] paddr,
	input  logic [cosu_pkg::APB_DW-1:0] pwdata,
	output logic [cosu_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);
	import cosu_pkg::*;

	// only cells below the 256 mask bits can ever be stored
	localparam int CELLS  = (CURSOR_SIZE * CURSOR_SIZE < MASK_BITS) ?
		CURSOR_SIZE * CURSOR_SIZE : MASK_BITS;
	localparam int ADDR_W = $clog2(CELLS);
	// wide enough for row * CURSOR_SIZE + col at the largest cell coordinates
	localparam int FULL_W = $clog2(16 * CURSOR_SIZE) + 1;
	localparam int MEM_W  = COLOR_W + PIXEL_W;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [COLOR_W-1:0] color_q;
	logic [COORD_W-1:0] width_q;
	logic [COORD_W-1:0] height_q;
	logic [MASK_W-1:0]  mask_q [MASK_REGS];
	cfg_reg_t           reg_sel;
	logic               cfg_wr;

	assign pready  = 1'b1;
	assign reg_sel = cfg_reg_t'(paddr[5:3]);
	assign cfg_wr  = psel && penable && pwrite && pready && (paddr[2:0] == 3'b000);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q  <= COLOR_RST;
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			for (int i = 0; i < MASK_REGS; i++) begin
				mask_q[i] <= '0;
			end
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_COLOR:  color_q   <= pwdata[COLOR_W-1:0];
				REG_WIDTH:  width_q   <= pwdata[COORD_W-1:0];
				REG_HEIGHT: height_q  <= pwdata[COORD_W-1:0];
				REG_MASK_0: mask_q[0] <= pwdata;
				REG_MASK_1: mask_q[1] <= pwdata;
				REG_MASK_2: mask_q[2] <= pwdata;
				REG_MASK_3: mask_q[3] <= pwdata;
				default: ;
			endcase
		end
	end

	// register read-back, zero extended
	always_comb begin
		case (reg_sel)
			REG_COLOR:  prdata = APB_DW'(color_q);
			REG_WIDTH:  prdata = APB_DW'(width_q);
			REG_HEIGHT: prdata = APB_DW'(height_q);
			REG_MASK_0: prdata = mask_q[0];
			REG_MASK_1: prdata = mask_q[1];
			REG_MASK_2: prdata = mask_q[2];
			REG_MASK_3: prdata = mask_q[3];
			default:    prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// pipeline handshake: each stage loads when empty or when it drains
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3;
	logic rdy2, rdy3;
	logic acc_in, adv1, adv2;

	assign rdy3     = !v_s3 || m_tready;
	assign rdy2     = !v_s2 || rdy3;
	assign s_tready = !v_s1 || rdy2;
	assign acc_in   = s_tvalid && s_tready;
	assign adv1     = v_s1 && rdy2;
	assign adv2     = v_s2 && rdy3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (s_tready) v_s1 <= s_tvalid;
			if (rdy2)     v_s2 <= v_s1;
			if (rdy3)     v_s3 <= v_s2;
		end
	end

	// ------------------------------------------------------------------
	// stage 1: unpack, screen position of the cell
	// ------------------------------------------------------------------
	cmd_t                cmd_s1;
	logic [CELL_W-1:0]   col_s1;
	logic [CELL_W-1:0]   row_s1;
	logic [SCREEN_W-1:0] sx_s1;
	logic [SCREEN_W-1:0] sy_s1;
	logic [PIXEL_W-1:0]  pix_s1;

	always_ff @(posedge clk) begin
		if (acc_in) begin
			cmd_s1 <= cmd_t'(s_tuser);
			col_s1 <= s_tdata[27:24];
			row_s1 <= s_tdata[31:28];
			sx_s1  <= SCREEN_W'(s_tdata[11:0]) + SCREEN_W'(s_tdata[27:24]);
			sy_s1  <= SCREEN_W'(s_tdata[23:12]) + SCREEN_W'(s_tdata[31:28]);
			pix_s1 <= s_tdata[63:32];
		end
	end

	// clip, cursor bounds and mask lookup
	logic [FULL_W-1:0]    idx_full;
	logic [7:0]           idx8;
	logic [ADDR_W-1:0]    addr_s1;
	logic [MASK_BITS-1:0] mask_vec;
	logic                 in_cursor;
	logic                 on_screen;
	logic                 hit_s1;
	logic                 mem_we;

	// first register holds the lowest cells, MSB first
	assign mask_vec  = {mask_q[0], mask_q[1], mask_q[2], mask_q[3]};
	assign idx_full  = FULL_W'(row_s1) * FULL_W'(CURSOR_SIZE) + FULL_W'(col_s1);
	assign idx8      = idx_full[7:0];
	assign addr_s1   = idx_full[ADDR_W-1:0];
	assign in_cursor = (32'(row_s1) < 32'(CURSOR_SIZE)) && (32'(col_s1) < 32'(CURSOR_SIZE))
		&& (32'(idx_full) < 32'(MASK_BITS));
	assign on_screen = (sx_s1 < SCREEN_W'(width_q)) && (sy_s1 < SCREEN_W'(height_q));
	assign hit_s1    = on_screen && in_cursor && mask_vec[~idx8];
	assign mem_we    = adv1 && (cmd_s1 == CMD_DRAW) && hit_s1;

	// ------------------------------------------------------------------
	// save-under memory: drawn color in the upper bits, saved pixel below
	// a cell never written reads as zero through its valid bit
	// ------------------------------------------------------------------
	logic [MEM_W-1:0] cell_mem [CELLS];
	logic [CELLS-1:0] cell_vld_q;
	logic             drawn_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			cell_mem[addr_s1] <= {color_q, pix_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_vld_q <= '0;
			drawn_q    <= 1'b0;
		end else if (adv1 && (cmd_s1 == CMD_DRAW)) begin
			// any draw marks the cursor as drawn, clipped or not
			drawn_q <= 1'b1;
			if (hit_s1) cell_vld_q[addr_s1] <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// stage 2: memory read data, compare against the drawn value
	// ------------------------------------------------------------------
	logic                draw_hit_s2;
	logic                clr_ok_s2;
	logic [SCREEN_W-1:0] sx_s2;
	logic [SCREEN_W-1:0] sy_s2;
	logic [PIXEL_W-1:0]  pix_s2;
	logic [COLOR_W-1:0]  color_s2;
	logic [MEM_W-1:0]    rd_s2;
	logic                rd_vld_s2;

	always_ff @(posedge clk) begin
		if (adv1) begin
			draw_hit_s2 <= (cmd_s1 == CMD_DRAW) && hit_s1;
			clr_ok_s2   <= (cmd_s1 == CMD_CLEAR) && hit_s1 && drawn_q;
			sx_s2       <= sx_s1;
			sy_s2       <= sy_s1;
			pix_s2      <= pix_s1;
			color_s2    <= color_q;
			rd_s2       <= cell_mem[addr_s1];
			rd_vld_s2   <= cell_vld_q[addr_s1];
		end
	end

	logic [COLOR_W-1:0] drawn_val;
	logic [PIXEL_W-1:0] saved_val;
	logic               clr_hit;
	logic               we_s2;
	logic [PIXEL_W-1:0] wcolor_s2;

	assign drawn_val = rd_vld_s2 ? rd_s2[MEM_W-1:PIXEL_W] : '0;
	assign saved_val = rd_vld_s2 ? rd_s2[PIXEL_W-1:0] : '0;
	// restore only if nobody overwrote the cursor pixel
	assign clr_hit   = clr_ok_s2 && (pix_s2 == PIXEL_W'(drawn_val));
	assign we_s2     = draw_hit_s2 || clr_hit;

	always_comb begin
		if (draw_hit_s2) begin
			wcolor_s2 = PIXEL_W'(color_s2);
		end else if (clr_hit) begin
			wcolor_s2 = saved_val;
		end else begin
			wcolor_s2 = '0;
		end
	end

	// ------------------------------------------------------------------
	// stage 3: output register
	// ------------------------------------------------------------------
	logic                we_s3;
	logic [SCREEN_W-1:0] x_s3;
	logic [SCREEN_W-1:0] y_s3;
	logic [PIXEL_W-1:0]  wcolor_s3;

	always_ff @(posedge clk) begin
		if (adv2) begin
			we_s3     <= we_s2;
			x_s3      <= sx_s2;
			y_s3      <= sy_s2;
			wcolor_s3 <= wcolor_s2;
		end
	end

	assign m_tvalid = v_s3;
	assign m_tuser  = we_s3;
	assign m_tdata  = OUT_DW'({wcolor_s3, y_s3, x_s3});

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	`COSU_ASSERT(a_clear_needs_draw, (adv1 && (cmd_s1 == CMD_CLEAR) && !drawn_q) |=> !clr_ok_s2, "clear restored before any draw")
	`COSU_ASSERT(a_draw_sets_flag, (adv1 && (cmd_s1 == CMD_DRAW)) |=> drawn_q, "draw did not mark cursor drawn")
	`COSU_ASSERT(a_no_write_zero, (m_tvalid && !m_tuser) |-> (m_tdata[57:26] == '0), "color not zero without write")
	`COSU_ASSERT(a_hit_kinds, (v_s2 && draw_hit_s2) |-> !clr_ok_s2, "cell both drawn and cleared")

endmodule
